FILE: rtl/mpqdk_pkg.sv
`default_nettype none

package mpqdk_pkg;

	// Default sizes of the queue storage.
	localparam int DEF_CAPACITY      = 64;
	localparam int DEF_PRIORITY_BITS = 16;
	localparam int DEF_ID_BITS       = 32;

	// Arrival stamps run modulo 2^32 whatever the other sizes are.
	localparam int ARRIVAL_BITS = 32;

	// Request codes carried in req_type.
	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_PROCESS = 2'd1,
		REQ_UPGRADE = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_code_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_EMPTY        = 3'd1,
		ST_FULL         = 3'd2,
		ST_NOT_FOUND    = 3'd3,
		ST_NOT_DECREASE = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_OP,
		S_APPLY,
		S_SCAN_FRONT,
		S_LATCH,
		S_RESP
	} state_t;

	// Request word.
	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] entry_id;
		logic [15:0] entry_priority;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] served_id;
		logic [31:0] front_id;
		logic [15:0] front_priority;
		logic [6:0]  entry_count;
	} out_word_t;

endpackage

`default_nettype wire

FILE: rtl/mpqdk_mem.sv
`default_nettype none

module mpqdk_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 80
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mpqdk_cmp.sv
`default_nettype none

module mpqdk_cmp #(
	parameter int PRIORITY_BITS = 16,
	parameter int ID_BITS       = 32
) (
	input  wire logic                                 cand_valid,
	input  wire logic                                 match_mode,
	input  wire logic [ID_BITS-1:0]                   key_id,
	input  wire logic [ID_BITS-1:0]                   cand_id,
	input  wire logic [PRIORITY_BITS-1:0]             cand_prio,
	input  wire logic [mpqdk_pkg::ARRIVAL_BITS-1:0]   cand_age,
	input  wire logic                                 best_found,
	input  wire logic [PRIORITY_BITS-1:0]             best_prio,
	input  wire logic [mpqdk_pkg::ARRIVAL_BITS-1:0]   best_age,
	output logic                                      take
);

	import mpqdk_pkg::*;

	logic eligible;
	logic better;

	// A slot competes when it is held and, for a lookup, carries the key.
	assign eligible = cand_valid && (!match_mode || (cand_id == key_id));

	// Smaller priority wins; on equal priority the older entry wins.
	assign better = (cand_prio < best_prio) ||
			((cand_prio == best_prio) && (cand_age > best_age));

	assign take = eligible && (!best_found || better);

endmodule

`default_nettype wire

FILE: rtl/min_priority_queue_with_decrease_key.sv
`default_nettype none

// Bounded minimum-priority queue of (id, priority) entries held in an unsorted slot memory.
// A request word is taken only when in_ready is high, and the block works on one request
// at a time. An insert, process or upgrade that changes the queue ends with a scan of all
// CAPACITY slots through the one registered slot memory read port and a shared compare
// unit, one slot per cycle, to find the new front and the lowest free slot. A process and
// an upgrade first scan for their target; a failed upgrade scans for its target only.
// Clear, insert on a full queue and process on an empty queue do no scan. The result word
// waits in an output register until taken, and the next request cannot finish while an
// earlier word still waits there. There is no clearing pass after reset.
module min_priority_queue_with_decrease_key #(
	parameter int CAPACITY      = mpqdk_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = mpqdk_pkg::DEF_PRIORITY_BITS,
	parameter int ID_BITS       = mpqdk_pkg::DEF_ID_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire mpqdk_pkg::in_word_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output mpqdk_pkg::out_word_t      out_data
);

	import mpqdk_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = ARRIVAL_BITS + PRIORITY_BITS + ID_BITS;
	localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	state_t state_q, state_d;

	// Latched request.
	in_word_t                 req_q;
	logic [ID_BITS-1:0]       key_id;
	logic [PRIORITY_BITS-1:0] key_prio;

	// Queue bookkeeping.
	logic [CAPACITY-1:0]     slot_valid_q;
	logic [CW-1:0]           count_q;
	logic [ARRIVAL_BITS-1:0] arrival_q;
	logic [IW-1:0]           first_free_q;
	logic                    ff_seen_q;
	logic [ID_BITS-1:0]       front_id_q;
	logic [PRIORITY_BITS-1:0] front_prio_q;
	status_t                 status_q;
	logic [ID_BITS-1:0]       served_q;

	// Scan counter and read stage.
	logic [IW-1:0] addr_q;
	logic          issue_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          sv_s1;
	logic          scan_last;

	// Best slot found so far in the current scan.
	logic                     best_found_q;
	logic [IW-1:0]            best_idx_q;
	logic [ID_BITS-1:0]       best_id_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic [ARRIVAL_BITS-1:0]  best_stamp_q;

	// Memory and compare unit connections.
	logic [MW-1:0]            rdata;
	logic [ID_BITS-1:0]       cand_id;
	logic [PRIORITY_BITS-1:0] cand_prio;
	logic [ARRIVAL_BITS-1:0]  cand_stamp;
	logic [ARRIVAL_BITS-1:0]  cand_age;
	logic [ARRIVAL_BITS-1:0]  best_age;
	logic                     match_mode;
	logic                     take;
	logic                     mem_we;
	logic [IW-1:0]            mem_waddr;
	logic [MW-1:0]            mem_wdata;

	// Sequencer outputs.
	logic accept;
	logic scan_start;
	logic out_load;
	logic upg_ok;

	out_word_t out_q;
	logic      out_valid_q;

	assign key_id   = ID_BITS'(req_q.entry_id);
	assign key_prio = PRIORITY_BITS'(req_q.entry_priority);

	// Slot word layout: arrival stamp, priority, id.
	assign cand_id    = rdata[ID_BITS-1:0];
	assign cand_prio  = rdata[ID_BITS +: PRIORITY_BITS];
	assign cand_stamp = rdata[ID_BITS + PRIORITY_BITS +: ARRIVAL_BITS];
	assign cand_age   = arrival_q - cand_stamp;
	assign best_age   = arrival_q - best_stamp_q;

	assign scan_last  = vld_s1 && (idx_s1 == LAST);
	assign match_mode = (state_q == S_SCAN_OP) && (req_q.req_type == REQ_UPGRADE);
	assign upg_ok     = best_found_q && (best_prio_q > key_prio);

	mpqdk_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (MW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue_q),
		.raddr (addr_q),
		.rdata (rdata)
	);

	mpqdk_cmp #(
		.PRIORITY_BITS (PRIORITY_BITS),
		.ID_BITS       (ID_BITS)
	) u_cmp (
		.cand_valid (vld_s1 && sv_s1),
		.match_mode (match_mode),
		.key_id     (key_id),
		.cand_id    (cand_id),
		.cand_prio  (cand_prio),
		.cand_age   (cand_age),
		.best_found (best_found_q),
		.best_prio  (best_prio_q),
		.best_age   (best_age),
		.take       (take)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_data.req_type)
						REQ_INSERT:  state_d = (count_q == FULL_COUNT) ? S_RESP : S_APPLY;
						REQ_PROCESS: state_d = (count_q == '0) ? S_RESP : S_SCAN_OP;
						REQ_UPGRADE: state_d = S_SCAN_OP;
						default:     state_d = S_APPLY;
					endcase
				end
			end
			S_SCAN_OP: begin
				if (scan_last) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				case (req_q.req_type)
					REQ_UPGRADE: state_d = upg_ok ? S_SCAN_FRONT : S_RESP;
					REQ_CLEAR:   state_d = S_RESP;
					default:     state_d = S_SCAN_FRONT;
				endcase
			end
			S_SCAN_FRONT: begin
				if (scan_last) begin
					state_d = S_LATCH;
				end
			end
			S_LATCH: state_d = S_RESP;
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		accept     = in_valid && (state_q == S_IDLE);
		out_load   = (state_q == S_RESP) && (!out_valid_q || out_ready);
		scan_start = ((state_d == S_SCAN_OP) && (state_q != S_SCAN_OP)) ||
				((state_d == S_SCAN_FRONT) && (state_q != S_SCAN_FRONT));
		mem_we     = 1'b0;
		mem_waddr  = best_idx_q;
		mem_wdata  = {best_stamp_q, key_prio, best_id_q};
		if (state_q == S_APPLY) begin
			case (req_q.req_type)
				REQ_INSERT: begin
					mem_we    = 1'b1;
					mem_waddr = first_free_q;
					mem_wdata = {arrival_q, key_prio, key_id};
				end
				REQ_UPGRADE: mem_we = upg_ok;
				default:     mem_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
	end

	// Scan address counter and read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue_q;
			if (scan_start) begin
				addr_q  <= '0;
				issue_q <= 1'b1;
			end else if (issue_q) begin
				addr_q <= addr_q + 1'b1;
				if (addr_q == LAST) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		sv_s1  <= slot_valid_q[addr_q];
	end

	// Best slot tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (scan_start) begin
			best_found_q <= 1'b0;
		end else if (take) begin
			best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= idx_s1;
			best_id_q    <= cand_id;
			best_prio_q  <= cand_prio;
			best_stamp_q <= cand_stamp;
		end
	end

	// Queue bookkeeping, applied once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			count_q      <= '0;
			arrival_q    <= '0;
			first_free_q <= '0;
			ff_seen_q    <= 1'b0;
			front_id_q   <= '0;
			front_prio_q <= '0;
			status_q     <= ST_OK;
			served_q     <= '0;
		end else begin
			if (accept) begin
				served_q <= '0;
				if ((in_data.req_type == REQ_INSERT) && (count_q == FULL_COUNT)) begin
					status_q <= ST_FULL;
				end else if ((in_data.req_type == REQ_PROCESS) && (count_q == '0)) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= ST_OK;
				end
			end
			if (state_q == S_APPLY) begin
				case (req_q.req_type)
					REQ_INSERT: begin
						slot_valid_q[first_free_q] <= 1'b1;
						count_q   <= count_q + 1'b1;
						arrival_q <= arrival_q + 1'b1;
					end
					REQ_PROCESS: begin
						slot_valid_q[best_idx_q] <= 1'b0;
						count_q  <= count_q - 1'b1;
						served_q <= best_id_q;
					end
					REQ_UPGRADE: begin
						if (!best_found_q) begin
							status_q <= ST_NOT_FOUND;
						end else if (!upg_ok) begin
							status_q <= ST_NOT_DECREASE;
						end
					end
					default: begin
						slot_valid_q <= '0;
						count_q      <= '0;
						arrival_q    <= '0;
						first_free_q <= '0;
						front_id_q   <= '0;
						front_prio_q <= '0;
					end
				endcase
			end
			// The front scan also finds the lowest free slot for the next insert.
			if (scan_start) begin
				ff_seen_q <= 1'b0;
			end else if ((state_q == S_SCAN_FRONT) && vld_s1 && !sv_s1 && !ff_seen_q) begin
				ff_seen_q    <= 1'b1;
				first_free_q <= idx_s1;
			end
			if (state_q == S_LATCH) begin
				front_id_q   <= best_found_q ? best_id_q : '0;
				front_prio_q <= best_found_q ? best_prio_q : '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.status         <= status_q;
			out_q.served_id      <= 32'(served_q);
			out_q.front_id       <= 32'(front_id_q);
			out_q.front_priority <= 16'(front_prio_q);
			out_q.entry_count    <= 7'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: rtl/mpqdk_checker.sv
`default_nettype none

module mpqdk_checker #(
	parameter int CAPACITY = mpqdk_pkg::DEF_CAPACITY
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire mpqdk_pkg::out_word_t out_data
);

	import mpqdk_pkg::*;

	// One request is worked on at a time, so ready drops after each accepted word.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one still in progress");

	// The count never exceeds the queue size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.entry_count <= 7'(CAPACITY)))
		else $error("entry count above capacity");

	// An empty queue reports a zero front.
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.entry_count == '0) |->
			(out_data.front_id == '0) && (out_data.front_priority == '0))
		else $error("empty queue with a non-zero front");

	// A failed process leaves nothing served and nothing held.
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_EMPTY) |->
			(out_data.served_id == '0) && (out_data.entry_count == '0))
		else $error("empty status with served id or entries");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

endmodule

bind min_priority_queue_with_decrease_key mpqdk_checker #(
	.CAPACITY (CAPACITY)
) u_mpqdk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
